// ===== rtl/core/wbc_pkg.sv =====
// Shared types and constants of the whitespace byte compactor.
package wbc_pkg;

  // Largest lane count that the fixed 128-bit item payload can carry.
  localparam int unsigned MaxLanes = 16;

  // Bytes at or below this value are dropped.
  localparam logic [7:0] SpaceLimit = 8'd32;

  // Depth of the result queue; a power of two so the pointers wrap freely.
  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);

  // One result word as it leaves the block.
  typedef struct packed {
    logic [63:0] packed_low;
    logic [63:0] packed_high;
    logic [4:0]  packed_count;
    logic        final_word;
    logic [31:0] total_kept;
  } word_t;

  // Words that one accepted input transaction pushes into the result queue.
  typedef struct packed {
    logic [1:0] num;
    word_t      w0;
    word_t      w1;
  } push_t;

endpackage

// ===== rtl/core/wbc_stream_if.sv =====
// Input and output stream interfaces of the whitespace byte compactor.
interface wbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] bytes_low;
  logic [63:0] bytes_high;
  logic [4:0]  valid_bytes;
  logic        end_of_stream;

  modport source (output valid, bytes_low, bytes_high, valid_bytes, end_of_stream,
                  input ready);
  modport sink   (input valid, bytes_low, bytes_high, valid_bytes, end_of_stream,
                  output ready);
endinterface

interface wbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_low;
  logic [63:0] packed_high;
  logic [4:0]  packed_count;
  logic        final_word;
  logic [31:0] total_kept;

  modport source (output valid, packed_low, packed_high, packed_count, final_word,
                  total_kept, input ready);
  modport sink   (input valid, packed_low, packed_high, packed_count, final_word,
                  total_kept, output ready);
endinterface

// ===== rtl/core/wbc_lane.sv =====
// One byte lane: decides whether its byte is valid and survives the filter.
module wbc_lane #(
  parameter int unsigned IDX = 0
) (
  input  logic [7:0] byte_i,
  input  logic [4:0] valid_bytes_i,
  output logic       keep_o
);
  import wbc_pkg::*;

  // A count above the lane width makes every lane valid, which covers clamping.
  assign keep_o = (valid_bytes_i > 5'(IDX)) && (byte_i > SpaceLimit);

endmodule

// ===== rtl/core/wbc_merge.sv =====
// Merging stage: packs the kept lane bytes behind the carry buffer and forms result words.
module wbc_merge #(
  parameter int unsigned LANE_BYTES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [LANE_BYTES*8-1:0] data_i,
  input  logic [LANE_BYTES-1:0]   keep_i,
  input  logic                    eos_i,
  output wbc_pkg::push_t          push_o
);
  import wbc_pkg::*;

  localparam int unsigned CntW  = $clog2(LANE_BYTES + 1);
  localparam int unsigned FillW = $clog2(LANE_BYTES);
  localparam int unsigned SumW  = $clog2(2 * LANE_BYTES);
  localparam int unsigned LaneW = LANE_BYTES * 8;

  logic [LaneW-1:0]   carry_q, carry_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [31:0]        total_q, total_d;

  logic [CntW-1:0]    pre [LANE_BYTES];
  logic [CntW-1:0]    added;
  logic [LaneW-1:0]   comp;
  logic [LaneW-1:0]   carry_masked;
  logic [2*LaneW-1:0] buf_w;
  logic [32:0]        total_sum;
  logic [31:0]        total_new;
  logic [SumW-1:0]    sum_fill;
  logic               full;
  logic [FillW-1:0]   rest;
  logic [127:0]       low_half, high_half;
  word_t              word_full, word_flush;

  // Prefix count of kept bytes gives each kept byte its packed position.
  always_comb begin
    logic [CntW-1:0] acc;
    acc = '0;
    for (int j = 0; j < LANE_BYTES; j++) begin
      pre[j] = acc;
      acc    = acc + CntW'(keep_i[j]);
    end
    added = acc;
  end

  always_comb begin
    comp = '0;
    for (int j = 0; j < LANE_BYTES; j++) begin
      for (int k = 0; k <= j; k++) begin
        if (keep_i[j] && (pre[j] == CntW'(k))) begin
          comp[8*k +: 8] = comp[8*k +: 8] | data_i[8*j +: 8];
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < LANE_BYTES; p++) begin
      carry_masked[8*p +: 8] = (FillW'(p) < fill_q) ? carry_q[8*p +: 8] : 8'h00;
    end
  end

  // Entries past the fill level are zero, so the packed words need no extra mask.
  assign buf_w = {{LaneW{1'b0}}, carry_masked} | ({{LaneW{1'b0}}, comp} << {fill_q, 3'b000});

  assign total_sum = {1'b0, total_q} + 33'(added);
  assign total_new = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
  assign sum_fill  = SumW'(fill_q) + SumW'(added);
  assign full      = sum_fill >= SumW'(LANE_BYTES);
  assign rest      = FillW'(sum_fill - SumW'(LANE_BYTES));

  assign low_half  = 128'(buf_w[LaneW-1:0]);
  assign high_half = 128'(buf_w[2*LaneW-1:LaneW]);

  always_comb begin
    word_full.packed_low   = low_half[63:0];
    word_full.packed_high  = low_half[127:64];
    word_full.packed_count = 5'(LANE_BYTES);
    word_full.final_word   = eos_i && (rest == '0);
    word_full.total_kept   = total_new;

    word_flush.packed_low   = full ? high_half[63:0] : low_half[63:0];
    word_flush.packed_high  = full ? high_half[127:64] : low_half[127:64];
    word_flush.packed_count = full ? 5'(rest) : 5'(sum_fill);
    word_flush.final_word   = 1'b1;
    word_flush.total_kept   = total_new;
  end

  always_comb begin
    push_o.w0  = full ? word_full : word_flush;
    push_o.w1  = word_flush;
    push_o.num = '0;
    if (fire_i) begin
      push_o.num = 2'(full) + 2'(eos_i && !(full && (rest == '0)));
    end
  end

  always_comb begin
    carry_d = full ? buf_w[2*LaneW-1:LaneW] : buf_w[LaneW-1:0];
    fill_d  = eos_i ? '0 : (full ? rest : FillW'(sum_fill));
    total_d = eos_i ? '0 : total_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else if (fire_i) begin
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      carry_q <= carry_d;
    end
  end

endmodule

// ===== rtl/core/wbc_outq.sv =====
// Result queue: takes up to two words per cycle and hands out one per transaction.
module wbc_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wbc_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output wbc_pkg::word_t head_o
);
  import wbc_pkg::*;

  word_t                 mem_q [OutqDepth];
  logic [OutqPtrW-1:0]   wr_q, rd_q;
  logic [OutqPtrW:0]     cnt_q;
  logic [OutqPtrW-1:0]   wr_next;

  assign wr_next = wr_q + OutqPtrW'(1);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  // Two free entries cover the worst case of one input transaction.
  assign room_o  = cnt_q <= (OutqPtrW + 1)'(OutqDepth - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.w0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OutqPtrW'(push_i.num);
      rd_q  <= rd_q + OutqPtrW'(pop_i);
      cnt_q <= cnt_q + (OutqPtrW + 1)'(push_i.num) - (OutqPtrW + 1)'(pop_i);
    end
  end

endmodule

// ===== rtl/core/whitespace_byte_compactor.sv =====
// Top level of the whitespace byte compactor: byte lanes, merge stage and result queue.
// A result word is written into the result queue when the input transaction that completes it is accepted.
// Throughput: one input transaction per cycle while the queue has room; the result port delivers one word
// per cycle while the consumer is ready, so the second word of a final item that yields two waits in the queue.
// Reset (asynchronous, active low) empties the result queue and clears the carry fill
// and the running kept-byte total; carry data and queue entries are not reset.
module whitespace_byte_compactor #(
  parameter int unsigned LANE_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wbc_in_if.sink           in_i,
  wbc_out_if.source        out_o
);
  import wbc_pkg::*;

  localparam int unsigned LaneW = LANE_BYTES * 8;

  logic [127:0]          in_bytes;
  logic [LaneW-1:0]      lane_data;
  logic [LANE_BYTES-1:0] keep;
  logic                  in_fire;
  logic                  room;
  push_t                 push;
  word_t                 head;

  // Bytes at or past the lane count are simply not wired to any lane.
  assign in_bytes  = {in_i.bytes_high, in_i.bytes_low};
  assign lane_data = in_bytes[LaneW-1:0];

  // The input is ready whenever the queue can absorb the two words that a
  // final item may produce, independent of whether the output side is stalled.
  assign in_i.ready = room;
  assign in_fire    = in_i.valid && room;

  // Each lane classifies one byte in parallel.
  for (genvar g = 0; g < LANE_BYTES; g++) begin : g_lane
    wbc_lane #(
      .IDX (g)
    ) u_lane (
      .byte_i        (lane_data[8*g +: 8]),
      .valid_bytes_i (in_i.valid_bytes),
      .keep_o        (keep[g])
    );
  end

  // The merge stage holds the carry buffer and the stream totals; it is
  // updated once per accepted transaction.
  wbc_merge #(
    .LANE_BYTES (LANE_BYTES)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .data_i (lane_data),
    .keep_i (keep),
    .eos_i  (in_i.end_of_stream),
    .push_o (push)
  );

  // The queue decouples the two sides so a stalled consumer does not stop
  // the input until the queue runs short of space.
  wbc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.valid && out_o.ready),
    .room_o  (room),
    .valid_o (out_o.valid),
    .head_o  (head)
  );

  assign out_o.packed_low   = head.packed_low;
  assign out_o.packed_high  = head.packed_high;
  assign out_o.packed_count = head.packed_count;
  assign out_o.final_word   = head.final_word;
  assign out_o.total_kept   = head.total_kept;

endmodule

// ===== tb/sv/wbc_stream_checker.sv =====
// Checker that predicts and compares the compacted words of the whitespace byte compactor.
module wbc_stream_checker #(
  parameter int unsigned LANE_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wbc_in_if           in_mon,
  wbc_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_o,
  output int unsigned finals_o
);
  import wbc_pkg::*;

  // Kept bytes waiting for a full word, and the kept-byte count of the open stream.
  logic [127:0] held_bytes   = '0;
  int unsigned  held_count   = 0;
  logic [31:0]  stream_total = '0;

  word_t       awaited_words[$];
  int unsigned fails  = 0;
  int unsigned words  = 0;
  int unsigned finals = 0;

  function automatic word_t pack_word(input logic [255:0] merged, input int unsigned count,
                                      input logic end_flag);
    word_t        w;
    logic [127:0] data;
    data = '0;
    for (int i = 0; i < MaxLanes; i++) begin
      if (i < count) data[8*i +: 8] = merged[8*i +: 8];
    end
    w.packed_low   = data[63:0];
    w.packed_high  = data[127:64];
    w.packed_count = 5'(count);
    w.final_word   = end_flag;
    w.total_kept   = stream_total;
    return w;
  endfunction

  // Drops blank bytes of one transaction, appends the rest to the held bytes
  // and queues every word that this completes.
  task automatic compact_item(input logic [127:0] data, input logic [4:0] nvalid,
                              input logic end_flag);
    logic [255:0] merged;
    logic [32:0]  sum;
    logic [7:0]   b;
    int unsigned  fill;
    int unsigned  lanes;
    int unsigned  added;
    int unsigned  rest;
    merged = '0;
    merged[127:0] = held_bytes;
    fill  = held_count;
    lanes = (nvalid > LANE_BYTES) ? LANE_BYTES : nvalid;
    added = 0;
    for (int i = 0; i < MaxLanes; i++) begin
      if (i < lanes) begin
        b = data[8*i +: 8];
        if (b > SpaceLimit) begin
          merged[8*(fill + added) +: 8] = b;
          added++;
        end
      end
    end
    sum = {1'b0, stream_total} + 33'(added);
    stream_total = sum[32] ? '1 : sum[31:0];
    fill += added;
    if (fill >= LANE_BYTES) begin
      rest = fill - LANE_BYTES;
      awaited_words.push_back(pack_word(merged, LANE_BYTES, end_flag && rest == 0));
      merged = merged >> (8 * LANE_BYTES);
      fill = rest;
      if (end_flag && rest == 0) begin
        held_count   = 0;
        stream_total = '0;
        return;
      end
    end
    if (end_flag) begin
      awaited_words.push_back(pack_word(merged, fill, 1'b1));
      held_count   = 0;
      stream_total = '0;
      return;
    end
    held_bytes = merged[127:0];
    held_count = fill;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    word_t got;
    word_t want;
    got.packed_low   = out_mon.packed_low;
    got.packed_high  = out_mon.packed_high;
    got.packed_count = out_mon.packed_count;
    got.final_word   = out_mon.final_word;
    got.total_kept   = out_mon.total_kept;
    words++;
    if (got.final_word === 1'b1) finals++;
    if (awaited_words.size() == 0) begin
      fails++;
      $display("%0t: unexpected word: expected none, got count %0d low %0h high %0h",
               $time, got.packed_count, got.packed_low, got.packed_high);
      return;
    end
    want = awaited_words.pop_front();
    compare_field("packed_low", want.packed_low, got.packed_low);
    compare_field("packed_high", want.packed_high, got.packed_high);
    compare_field("packed_count", 64'(want.packed_count), 64'(got.packed_count));
    compare_field("final_word", 64'(want.final_word), 64'(got.final_word));
    compare_field("total_kept", 64'(want.total_kept), 64'(got.total_kept));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes   = '0;
      held_count   = 0;
      stream_total = '0;
      awaited_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        compact_item({in_mon.bytes_high, in_mon.bytes_low}, in_mon.valid_bytes,
                     in_mon.end_of_stream);
      end
      if (out_mon.valid && out_mon.ready) check_word();
    end
    fail_count_o <= fails;
    pending_o    <= awaited_words.size();
    words_o      <= words;
    finals_o     <= finals;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the whitespace byte compactor test: clock, reset, stimulus and verdict.
module testbench;
  import wbc_pkg::*;

  localparam int unsigned LaneBytes    = 16;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseItems   = 530;

  // Byte mixes used to build random transactions.
  typedef enum int unsigned {
    MixBlank,
    MixAny,
    MixText,
    MixBlend
  } byte_mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  wbc_in_if  in_ch ();
  wbc_out_if out_ch ();

  whitespace_byte_compactor #(
    .LANE_BYTES(LaneBytes)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_seen;
  int unsigned stream_ends;

  wbc_stream_checker #(
    .LANE_BYTES(LaneBytes)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .words_o     (words_seen),
    .finals_o    (stream_ends)
  );

  // Idle rates in percent. The sender rate is applied before each transaction,
  // the receiver rate decides ready on every cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  // The result ready is held in a variable of its own so that it is known from time zero.
  logic sink_ready = 1'b0;
  assign out_ch.ready = sink_ready;

  always @(posedge clk_i) begin
    sink_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // A hung handshake must never stall the run forever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("whitespace_byte_compactor test failed");
      $finish;
    end
  end

  // Offers one transaction, possibly after a random gap, and returns once it is taken.
  // The valid stays high into the next call, so back-to-back transactions need
  // only one assignment per edge.
  task automatic send_item(input logic [127:0] data, input logic [4:0] nvalid,
                           input logic end_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.bytes_low     <= data[63:0];
    in_ch.bytes_high    <= data[127:64];
    in_ch.valid_bytes   <= nvalid;
    in_ch.end_of_stream <= end_flag;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Holds the sender off until every word predicted so far has come out.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_byte(input byte_mix_e mix);
    int unsigned pick;
    pick = $urandom_range(9);
    case (mix)
      MixBlank: return 8'($urandom_range(32));
      MixAny:   return 8'($urandom_range(255));
      MixText:  return 8'($urandom_range(126, 33));
      default: begin
        // Mostly text with spaces and controls sprinkled in, and some bytes
        // with the top bit set to catch a signed compare.
        if (pick < 3)       return 8'($urandom_range(32));
        else if (pick == 3) return 8'($urandom_range(255));
        else if (pick == 4) return 8'($urandom_range(34, 31));
        else                return 8'($urandom_range(126, 33));
      end
    endcase
  endfunction

  // One stream of random transactions; the last one closes it. Most streams are
  // short so that stream ends and flushes come often, a few run long.
  task automatic send_stream();
    logic [127:0] data;
    logic [4:0]   nvalid;
    byte_mix_e    mix;
    int unsigned  len;
    int unsigned  pick;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(19);
      if (pick == 0)      mix = MixBlank;
      else if (pick == 1) mix = MixText;
      else if (pick < 4)  mix = MixAny;
      else                mix = MixBlend;
      for (int i = 0; i < MaxLanes; i++) data[8*i +: 8] = rand_byte(mix);
      // Full items dominate, with short counts and oversized counts mixed in.
      pick = $urandom_range(9);
      if (pick < 7)       nvalid = 5'd16;
      else if (pick < 9)  nvalid = 5'($urandom_range(15));
      else                nvalid = 5'($urandom_range(31, 17));
      send_item(data, nvalid, n == len - 1);
    end
  endtask

  initial begin
    int unsigned target;
    in_ch.valid         <= 1'b0;
    in_ch.bytes_low     <= '0;
    in_ch.bytes_high    <= '0;
    in_ch.valid_bytes   <= '0;
    in_ch.end_of_stream <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with moderate idling on both sides.
    send_idle_pct = 20;
    recv_idle_pct = 30;
    // All bytes kept: exactly one full word, nothing carried.
    send_item({16{8'hFF}}, 5'd16, 1'b0);
    // Nothing kept on the last item: an empty final word that still reports 16.
    send_item({16{8'h00}}, 5'd16, 1'b1);
    // Both sides of the threshold, the top-bit bytes and the common controls.
    send_item({64'h090A_0D20_2120_7E01, 64'h1F7F_8021_2000_FF41}, 5'd16, 1'b0);
    // A zero count drops the whole item even though every byte is printable.
    send_item({16{8'h41}}, 5'd0, 1'b0);
    // Bytes past the count are ignored.
    send_item({16{8'h42}}, 5'd5, 1'b0);
    // Counts above the lane width act as a full item.
    send_item({16{8'h43}}, 5'd31, 1'b0);
    send_item({16{8'h44}}, 5'd17, 1'b1);
    // A stream that ends on an exact full word: one word, marked final.
    send_item({16{8'h45}}, 5'd10, 1'b0);
    send_item({16{8'h46}}, 5'd6, 1'b1);
    // Empty stream ends: no bytes at all, then only spaces.
    send_item({16{8'h47}}, 5'd0, 1'b1);
    send_item({16{8'h20}}, 5'd16, 1'b1);
    // Fifteen bytes carried into a full last item: two words on one transaction.
    send_item({16{8'h48}}, 5'd15, 1'b0);
    send_item({16{8'h49}}, 5'd16, 1'b1);
    // Alternating bit patterns, then the smallest byte value that is kept.
    send_item({16{8'hAA}}, 5'd16, 1'b0);
    send_item({16{8'h55}}, 5'd16, 1'b1);
    send_item({16{8'h21}}, 5'd16, 1'b1);
    send_item({{8{8'h21}}, {8{8'h7E}}}, 5'd16, 1'b0);
    send_item({{8{8'h20}}, {8{8'hFE}}}, 5'd9, 1'b1);

    // Random part in three idling phases: receiver-heavy, sender-heavy, none.
    // Each phase starts with the sender held off until everything has drained.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_for_drain();
      target = items_sent + PhaseItems;
      while (items_sent < target) send_stream();
    end

    // Let the last words come out, then watch a while for stray ones.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d input transactions in directed and three random idling phases.",
             items_sent);
    $display("Checked %0d result words, %0d of them closing a stream.",
             words_seen, stream_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("whitespace_byte_compactor test passed");
    end else begin
      $display("whitespace_byte_compactor test failed");
    end
    $finish;
  end

endmodule
